@@ rtl/hnorm_pkg.sv @@
// Shared types and constants of the heightmap normal generator.
package hnorm_pkg;

    localparam int GREY_W  = 8;
    localparam int MH_W    = 4;
    localparam int GS_W    = 9;
    localparam int CO_W    = 8;
    localparam int AB_W    = 13;
    localparam int SQ_W    = 24;
    localparam int S_W     = 25;
    localparam int FRAC    = 30;
    localparam int NUM_W   = SQ_W + FRAC;
    localparam int ACC_W   = 60;
    localparam int Q_W     = 15;
    localparam int NX_W    = 16;
    localparam int IT_W    = 4;
    localparam int Q_DEPTH = 4;

    localparam logic [SQ_W-1:0]  Z_SQ     = SQ_W'(260100);
    localparam logic [Q_W-1:0]   Q_ONE    = Q_W'(16384);
    localparam logic [IT_W-1:0]  IT_LAST  = IT_W'(Q_W - 1);
    localparam logic [GS_W-1:0]  GS_RESET = GS_W'(256);
    localparam logic [MH_W-1:0]  MH_RESET = MH_W'(3);

    localparam logic CFG_GRID = 1'b0;
    localparam logic CFG_MAXH = 1'b1;

    typedef struct packed {
        logic signed [AB_W-1:0] a;
        logic signed [AB_W-1:0] b;
        logic [CO_W-1:0]        col;
        logic [CO_W-1:0]        row;
        logic                   last;
    } t_job;

    typedef enum logic [2:0] {
        F_IDLE, F_RD2, F_RD3, F_P0, F_P1, F_P2
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE, B_SQ, B_LD, B_IT, B_OUT
    } t_bstate;

endpackage

@@ rtl/hnorm_in_if.sv @@
// Request channel carrying grey height samples.
interface hnorm_in_if;
    logic                           valid;
    logic                           ready;
    logic [hnorm_pkg::GREY_W-1:0]   grey;
    modport source (output valid, output grey, input ready);
    modport sink (input valid, input grey, output ready);
endinterface

@@ rtl/hnorm_out_if.sv @@
// Result channel carrying unit normals with their grid position.
interface hnorm_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [hnorm_pkg::NX_W-1:0]  norm_x;
    logic signed [hnorm_pkg::NX_W-1:0]  norm_y;
    logic [hnorm_pkg::Q_W-1:0]          norm_z;
    logic [hnorm_pkg::CO_W-1:0]         col;
    logic [hnorm_pkg::CO_W-1:0]         row;
    logic                               last;
    modport source (output valid, output norm_x, output norm_y, output norm_z,
                    output col, output row, output last, input ready);
    modport sink (input valid, input norm_x, input norm_y, input norm_z,
                  input col, input row, input last, output ready);
endinterface

@@ rtl/hnorm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module hnorm_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/hnorm_fifo.sv @@
// Short job queue between the row front end and the normal engine.
module hnorm_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hnorm_pkg::t_job   i_data,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_valid,
    output hnorm_pkg::t_job   o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hnorm_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count overflow");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");
endmodule

@@ rtl/hnorm_unit.sv @@
// Bit-serial search of one Q1.14 normal magnitude: largest q with (2q-1)^2*s <= num.
module hnorm_unit (
    input  logic                            i_clk,
    input  logic                            i_load,
    input  logic                            i_step,
    input  logic [hnorm_pkg::NUM_W-1:0]     i_num,
    input  logic [hnorm_pkg::S_W-1:0]       i_s,
    output logic [hnorm_pkg::Q_W-1:0]       o_q
);
    localparam int AW = hnorm_pkg::ACC_W;
    localparam int K0 = hnorm_pkg::Q_W - 1;

    // r_p = x^2*s, r_a = s*x << (k+2), r_b = s << (2k+2), x = 2q-1
    logic signed [AW-1:0]        r_p;
    logic signed [AW-1:0]        r_a;
    logic signed [AW-1:0]        r_b;
    logic [hnorm_pkg::Q_W-1:0]   r_q;
    logic [hnorm_pkg::Q_W-1:0]   r_bit;
    logic signed [AW-1:0]        s_x;
    logic signed [AW-1:0]        cand;
    logic signed [AW-1:0]        a_upd;
    logic                        take;

    always_comb begin
        s_x   = $signed(AW'(i_s));
        cand  = r_p + r_a + r_b;
        take  = !r_q[K0] && (cand <= $signed(AW'(i_num)));
        a_upd = take ? (r_a + (r_b <<< 1)) : r_a;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_p   <= s_x;
            r_a   <= -(s_x <<< (K0 + 2));
            r_b   <= s_x <<< (2 * K0 + 2);
            r_q   <= '0;
            r_bit <= hnorm_pkg::Q_ONE;
        end else if (i_step) begin
            if (take) begin
                r_p <= cand;
                r_q <= r_q | r_bit;
            end
            r_a   <= a_upd >>> 1;
            r_b   <= r_b >>> 2;
            r_bit <= r_bit >> 1;
        end
    end

    assign o_q = r_q;
endmodule

@@ rtl/hnorm_front.sv @@
// Front end: row stores, neighbor gathering and job issue per height sample.
module hnorm_front #(
    parameter int MAX_GRID = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hnorm_in_if.sink                      i_req,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [hnorm_pkg::GS_W-1:0]    i_cfg_data,
    output hnorm_pkg::t_job               o_job,
    output logic                          o_job_valid,
    input  logic                          i_job_ready
);
    localparam int AW = $clog2(MAX_GRID);
    localparam int GW = hnorm_pkg::GREY_W;

    hnorm_pkg::t_fstate            r_state, n_state;
    logic [AW-1:0]                 r_col, r_row;
    logic [2*GW-1:0]               r_prev;
    logic [GW-1:0]                 r_g, r_mid, r_uc;
    logic [hnorm_pkg::GS_W-1:0]    r_gs;
    logic [hnorm_pkg::MH_W-1:0]    r_mh;
    logic                          r_pend_v;
    hnorm_pkg::t_job               r_pend;

    logic [31:0]     n_cl;
    logic [AW-1:0]   nm1;
    logic            c_last, c_zero, rw_last, rw_zero, lr_en;
    logic            m_re, u_re, st_we;
    logic [AW-1:0]   m_raddr, u_raddr;
    logic [GW-1:0]   m_rdata, u_rdata;
    logic [GW-1:0]   ctr;
    hnorm_pkg::t_job job_main, job_lr, job_pend;
    logic            leave;

    function automatic hnorm_pkg::t_job mk_job(
        input logic [GW-1:0] gl, input logic [GW-1:0] gr,
        input logic [GW-1:0] gt, input logic [GW-1:0] gb,
        input logic [hnorm_pkg::MH_W-1:0] mh,
        input logic [AW-1:0] col, input logic [AW-1:0] row, input logic last);
        hnorm_pkg::t_job       j;
        logic signed [GW:0]    dx, dy;
        logic signed [hnorm_pkg::MH_W:0] m;
        logic signed [GW+hnorm_pkg::MH_W+1:0] px, py;
        dx = $signed({1'b0, gl}) - $signed({1'b0, gr});
        dy = $signed({1'b0, gt}) - $signed({1'b0, gb});
        m  = $signed({1'b0, mh});
        px = dx * m;
        py = dy * m;
        j.a    = px[hnorm_pkg::AB_W-1:0];
        j.b    = py[hnorm_pkg::AB_W-1:0];
        j.col  = hnorm_pkg::CO_W'(col);
        j.row  = hnorm_pkg::CO_W'(row);
        j.last = last;
        return j;
    endfunction

    always_comb begin
        n_cl = 32'(r_gs);
        if (n_cl < 32'd2) begin
            n_cl = 32'd2;
        end
        if (n_cl > 32'(MAX_GRID)) begin
            n_cl = 32'(MAX_GRID);
        end
    end

    assign nm1     = AW'(n_cl - 32'd1);
    assign c_last  = (r_col == nm1);
    assign c_zero  = (r_col == '0);
    assign rw_last = (r_row == nm1);
    assign rw_zero = (r_row == '0);
    assign lr_en   = rw_last && !c_zero;
    assign ctr     = r_prev[GW-1:0];

    assign job_main = mk_job(c_zero ? r_mid : u_rdata, c_last ? r_mid : m_rdata,
                             r_g, (r_row == AW'(1)) ? r_mid : r_uc,
                             r_mh, r_col, r_row - 1'b1, 1'b0);
    assign job_lr   = mk_job((r_col == AW'(1)) ? ctr : r_prev[2*GW-1:GW], r_g,
                             ctr, u_rdata, r_mh, r_col - 1'b1, r_row, 1'b0);
    assign job_pend = mk_job(ctr, r_g, r_g, r_mid, r_mh, r_col, r_row, 1'b1);

    hnorm_ram #(.W(GW), .DEPTH(MAX_GRID)) u_upper (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_col),
        .i_wdata (r_mid),
        .i_re    (u_re),
        .i_raddr (u_raddr),
        .o_rdata (u_rdata)
    );

    hnorm_ram #(.W(GW), .DEPTH(MAX_GRID)) u_middle (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_col),
        .i_wdata (r_g),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hnorm_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        o_job_valid = 1'b0;
        o_job       = r_pend;
        m_re        = 1'b0;
        u_re        = 1'b0;
        m_raddr     = r_col;
        u_raddr     = r_col;
        st_we       = 1'b0;
        leave       = 1'b0;
        unique case (r_state)
            hnorm_pkg::F_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    m_re    = 1'b1;
                    u_re    = 1'b1;
                    n_state = hnorm_pkg::F_RD2;
                end
            end
            hnorm_pkg::F_RD2: begin
                m_re    = 1'b1;
                u_re    = 1'b1;
                m_raddr = c_last ? r_col : r_col + 1'b1;
                u_raddr = c_zero ? r_col : r_col - 1'b1;
                n_state = hnorm_pkg::F_RD3;
            end
            hnorm_pkg::F_RD3: begin
                st_we   = 1'b1;
                n_state = hnorm_pkg::F_P0;
            end
            hnorm_pkg::F_P0: begin
                o_job_valid = r_pend_v;
                o_job       = r_pend;
                if (!r_pend_v || i_job_ready) begin
                    n_state = hnorm_pkg::F_P1;
                end
            end
            hnorm_pkg::F_P1: begin
                o_job_valid = !rw_zero;
                o_job       = job_main;
                if (rw_zero || i_job_ready) begin
                    n_state = hnorm_pkg::F_P2;
                end
            end
            hnorm_pkg::F_P2: begin
                o_job_valid = lr_en;
                o_job       = job_lr;
                if (!lr_en || i_job_ready) begin
                    leave   = 1'b1;
                    n_state = hnorm_pkg::F_IDLE;
                end
            end
            default: n_state = hnorm_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == hnorm_pkg::F_IDLE && i_req.valid) begin
            r_g <= i_req.grey;
        end
        if (r_state == hnorm_pkg::F_RD2) begin
            r_mid <= m_rdata;
            r_uc  <= u_rdata;
        end
        if (leave && lr_en && c_last) begin
            r_pend <= job_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_prev   <= '0;
            r_gs     <= hnorm_pkg::GS_RESET;
            r_mh     <= hnorm_pkg::MH_RESET;
            r_pend_v <= 1'b0;
        end else begin
            if (r_state == hnorm_pkg::F_P0 && r_pend_v && i_job_ready) begin
                r_pend_v <= 1'b0;
            end
            if (leave) begin
                if (lr_en && c_last) begin
                    r_pend_v <= 1'b1;
                end
                r_prev <= {r_prev[GW-1:0], r_g};
                if (c_last) begin
                    r_col <= '0;
                    r_row <= rw_last ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hnorm_pkg::CFG_GRID: begin
                        r_gs     <= i_cfg_data;
                        r_col    <= '0;
                        r_row    <= '0;
                        r_pend_v <= 1'b0;
                    end
                    hnorm_pkg::CFG_MAXH: r_mh <= i_cfg_data[hnorm_pkg::MH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    a_pend_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_col == '0 && r_row == '0))
        else $error("held corner normal outside grid start");
endmodule

@@ rtl/hnorm_back.sv @@
// Normal engine: squares, three magnitude searches and the result register.
module hnorm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hnorm_pkg::t_job   i_job,
    input  logic              i_job_valid,
    output logic              o_job_pop,
    hnorm_out_if.source       o_rsp
);
    localparam int FR = hnorm_pkg::FRAC;

    hnorm_pkg::t_bstate              r_state, n_state;
    hnorm_pkg::t_job                 r_job;
    logic [hnorm_pkg::SQ_W-1:0]      r_a2, r_b2;
    logic [hnorm_pkg::IT_W-1:0]      r_it;
    logic                            r_ovalid;
    logic signed [hnorm_pkg::NX_W-1:0] r_nx, r_ny;
    logic [hnorm_pkg::Q_W-1:0]       r_nz;
    logic [hnorm_pkg::CO_W-1:0]      r_col, r_row;
    logic                            r_last;

    logic signed [2*hnorm_pkg::AB_W-1:0] a_sq, b_sq;
    logic [hnorm_pkg::S_W-1:0]       s_sum;
    logic                            load, step, out_load;
    logic [hnorm_pkg::Q_W-1:0]       qx, qy, qz;

    assign a_sq  = r_job.a * r_job.a;
    assign b_sq  = r_job.b * r_job.b;
    assign s_sum = hnorm_pkg::S_W'(r_a2) + hnorm_pkg::S_W'(r_b2)
                 + hnorm_pkg::S_W'(hnorm_pkg::Z_SQ);

    hnorm_unit u_x (.i_clk(i_clk), .i_load(load), .i_step(step),
        .i_num({r_a2, {FR{1'b0}}}), .i_s(s_sum), .o_q(qx));
    hnorm_unit u_y (.i_clk(i_clk), .i_load(load), .i_step(step),
        .i_num({r_b2, {FR{1'b0}}}), .i_s(s_sum), .o_q(qy));
    hnorm_unit u_z (.i_clk(i_clk), .i_load(load), .i_step(step),
        .i_num({hnorm_pkg::Z_SQ, {FR{1'b0}}}), .i_s(s_sum), .o_q(qz));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hnorm_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        load      = 1'b0;
        step      = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            hnorm_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_state   = hnorm_pkg::B_SQ;
                end
            end
            hnorm_pkg::B_SQ: n_state = hnorm_pkg::B_LD;
            hnorm_pkg::B_LD: begin
                load    = 1'b1;
                n_state = hnorm_pkg::B_IT;
            end
            hnorm_pkg::B_IT: begin
                step = 1'b1;
                if (r_it == hnorm_pkg::IT_LAST) begin
                    n_state = hnorm_pkg::B_OUT;
                end
            end
            hnorm_pkg::B_OUT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state  = hnorm_pkg::B_IDLE;
                end
            end
            default: n_state = hnorm_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
        end
        if (r_state == hnorm_pkg::B_SQ) begin
            r_a2 <= a_sq[hnorm_pkg::SQ_W-1:0];
            r_b2 <= b_sq[hnorm_pkg::SQ_W-1:0];
        end
        if (out_load) begin
            r_nx   <= r_job.a[hnorm_pkg::AB_W-1] ? -hnorm_pkg::NX_W'(qx)
                                                 : hnorm_pkg::NX_W'(qx);
            r_ny   <= r_job.b[hnorm_pkg::AB_W-1] ? -hnorm_pkg::NX_W'(qy)
                                                 : hnorm_pkg::NX_W'(qy);
            r_nz   <= qz;
            r_col  <= r_job.col;
            r_row  <= r_job.row;
            r_last <= r_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_it <= '0;
            end else if (step) begin
                r_it <= r_it + 1'b1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.norm_x = r_nx;
    assign o_rsp.norm_y = r_ny;
    assign o_rsp.norm_z = r_nz;
    assign o_rsp.col    = r_col;
    assign o_rsp.row    = r_row;
    assign o_rsp.last   = r_last;

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == hnorm_pkg::B_OUT |-> (qx <= hnorm_pkg::Q_ONE && qy <= hnorm_pkg::Q_ONE
                                         && qz <= hnorm_pkg::Q_ONE))
        else $error("normal component above one");
endmodule

@@ rtl/heightmap_normal_generator.sv @@
// Top level: heightmap to unit normal stream, front end, job queue and normal engine.
// A request is taken, row stores are read (F_IDLE, F_RD2) and jobs queue from F_P0 on.
// Each normal passes the engine as pop, square, load, 15 search steps and output.
// The front takes a new request only after F_P2; the sustained rate is set by the
// engine, which pops a new job only after its last output; about one normal per request.
// Reset: synchronous, active low; counters, queue and held normal clear, row stores do not.
module heightmap_normal_generator #(
    parameter int MAX_GRID = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hnorm_in_if.sink                      i_req,
    hnorm_out_if.source                   o_rsp,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [hnorm_pkg::GS_W-1:0]    i_cfg_data
);
    hnorm_pkg::t_job  fj, qj;
    logic             fj_valid, q_ready, q_valid, q_pop;

    hnorm_front #(.MAX_GRID(MAX_GRID)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_job       (fj),
        .o_job_valid (fj_valid),
        .i_job_ready (q_ready)
    );

    hnorm_fifo #(.DEPTH(hnorm_pkg::Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fj_valid),
        .i_data  (fj),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (qj)
    );

    hnorm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (qj),
        .i_job_valid (q_valid),
        .o_job_pop   (q_pop),
        .o_rsp       (o_rsp)
    );
endmodule
